@@ sv/brl_pkg.sv @@
// ----------------------------------------------------------------------------
// brl_pkg - shared types and constants of the line rasteriser
// Field widths, opcode and register codes, and the pixel record passed
// between the walk stage and the address stage.
// ----------------------------------------------------------------------------
package brl_pkg;

  // field widths
  localparam int unsigned COORD_W     = 12;
  localparam int unsigned FW_W        = 13;
  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned DEC_W       = COORD_W + 2;
  localparam int unsigned IN_TDATA_W  = 4 * COORD_W;
  localparam int unsigned OUT_TDATA_W = 2 * COORD_W + ADDR_W;

  // configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic [FW_W-1:0] FW_RESET = 13'd1024;
  localparam logic [APB_AW-3:0] REG_FRAME_WIDTH = 1'b0;

  // beat opcodes (tuser)
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // one pixel on its way to the address stage
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } pixel_t;

endpackage

@@ sv/brl_cfg.sv @@
// ----------------------------------------------------------------------------
// brl_cfg - configuration register file
// APB-style slave holding the frame width; pready is tied high.
// ----------------------------------------------------------------------------
module brl_cfg
  import brl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [FW_W-1:0]   frame_width_o
);

  logic [FW_W-1:0] frame_width_q, frame_width_d;
  logic            sel_fw;

  // word decode; byte offset bits ignored
  assign sel_fw = (paddr[APB_AW-1:2] == REG_FRAME_WIDTH);

  // write on the access phase
  always_comb begin
    frame_width_d = frame_width_q;
    if (psel && penable && pwrite && sel_fw) begin
      frame_width_d = pwdata[FW_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= FW_RESET;
    end else begin
      frame_width_q <= frame_width_d;
    end
  end

  // read back
  assign prdata        = sel_fw ? {{(APB_DW-FW_W){1'b0}}, frame_width_q} : '0;
  assign pready        = 1'b1;
  assign frame_width_o = frame_width_q;

endmodule

@@ sv/brl_walk.sv @@
// ----------------------------------------------------------------------------
// brl_walk - Bresenham walk state and pixel stage
// Sets up a line on a load beat and advances one pixel per step beat,
// handing each pixel to a one-entry register towards the address stage.
// ----------------------------------------------------------------------------
module brl_walk
  import brl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic [COORD_W-1:0] x_start_i,
  input  logic [COORD_W-1:0] y_start_i,
  input  logic [COORD_W-1:0] x_end_i,
  input  logic [COORD_W-1:0] y_end_i,
  output logic               pix_valid_o,
  input  logic               pix_ready_i,
  output pixel_t             pix_o
);

  // walk state
  logic               active_q, active_d;
  logic               xmaj_q, xmaj_d;
  logic [COORD_W-1:0] cur_x_q, cur_x_d;
  logic [COORD_W-1:0] cur_y_q, cur_y_d;
  logic [COORD_W-1:0] maj_end_q, maj_end_d;
  logic               step_down_q, step_down_d;
  logic [DEC_W-1:0]   dec_q, dec_d;
  logic [COORD_W-1:0] minor_q, minor_d;
  logic [COORD_W-1:0] major_q, major_d;

  // pixel stage
  logic               pv_q, pv_d;
  pixel_t             pix_q, pix_d;

  logic               accept, is_load, emit, last;
  logic [COORD_W-1:0] adx, ady, major_cur, minor_next;
  logic               dx_neg, dy_neg, dx_pos, dy_pos, xmaj_ld;
  logic [DEC_W-1:0]   two_minor, two_major;

  assign in_ready_o = !pv_q || pix_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_load    = (opcode_i == OP_LOAD);
  assign emit       = accept && (opcode_i == OP_STEP) && active_q;

  // load setup: spans and direction
  assign dx_neg  = x_end_i < x_start_i;
  assign dy_neg  = y_end_i < y_start_i;
  assign dx_pos  = x_end_i > x_start_i;
  assign dy_pos  = y_end_i > y_start_i;
  assign adx     = dx_neg ? (x_start_i - x_end_i) : (x_end_i - x_start_i);
  assign ady     = dy_neg ? (y_start_i - y_end_i) : (y_end_i - y_start_i);
  assign xmaj_ld = adx > ady;

  // step: end test and minor move
  assign major_cur  = xmaj_q ? cur_x_q : cur_y_q;
  assign last       = (major_cur == maj_end_q);
  assign minor_next = step_down_q ? ((xmaj_q ? cur_y_q : cur_x_q) - 1'b1)
                                  : ((xmaj_q ? cur_y_q : cur_x_q) + 1'b1);
  assign two_minor  = {1'b0, minor_q, 1'b0};
  assign two_major  = {1'b0, major_q, 1'b0};

  always_comb begin
    active_d    = active_q;
    xmaj_d      = xmaj_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    maj_end_d   = maj_end_q;
    step_down_d = step_down_q;
    dec_d       = dec_q;
    minor_d     = minor_q;
    major_d     = major_q;
    if (accept && is_load) begin
      active_d    = 1'b1;
      xmaj_d      = xmaj_ld;
      step_down_d = !((dx_pos && dy_pos) || (dx_neg && dy_neg));
      if (xmaj_ld) begin
        cur_x_d   = dx_neg ? x_end_i : x_start_i;
        cur_y_d   = dx_neg ? y_end_i : y_start_i;
        maj_end_d = dx_neg ? x_start_i : x_end_i;
        major_d   = adx;
        minor_d   = ady;
        dec_d     = {1'b0, ady, 1'b0} - {2'b00, adx};
      end else begin
        cur_x_d   = dy_neg ? x_end_i : x_start_i;
        cur_y_d   = dy_neg ? y_end_i : y_start_i;
        maj_end_d = dy_neg ? y_start_i : y_end_i;
        major_d   = ady;
        minor_d   = adx;
        dec_d     = {1'b0, adx, 1'b0} - {2'b00, ady};
      end
    end else if (emit) begin
      if (last) begin
        active_d = 1'b0;
      end else begin
        if (xmaj_q) begin
          cur_x_d = cur_x_q + 1'b1;
        end else begin
          cur_y_d = cur_y_q + 1'b1;
        end
        if (dec_q[DEC_W-1]) begin
          dec_d = dec_q + two_minor;
        end else begin
          dec_d = dec_q + two_minor - two_major;
          if (xmaj_q) begin
            cur_y_d = minor_next;
          end else begin
            cur_x_d = minor_next;
          end
        end
      end
    end
  end

  // pixel register
  always_comb begin
    pv_d  = pv_q;
    pix_d = pix_q;
    if (emit) begin
      pv_d       = 1'b1;
      pix_d.x    = cur_x_q;
      pix_d.y    = cur_y_q;
      pix_d.last = last;
    end else if (pix_ready_i) begin
      pv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      xmaj_q      <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      maj_end_q   <= '0;
      step_down_q <= 1'b0;
      dec_q       <= '0;
      minor_q     <= '0;
      major_q     <= '0;
      pv_q        <= 1'b0;
    end else begin
      active_q    <= active_d;
      xmaj_q      <= xmaj_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      maj_end_q   <= maj_end_d;
      step_down_q <= step_down_d;
      dec_q       <= dec_d;
      minor_q     <= minor_d;
      major_q     <= major_d;
      pv_q        <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign pix_valid_o = pv_q;
  assign pix_o       = pix_q;

endmodule

@@ sv/brl_addr.sv @@
// ----------------------------------------------------------------------------
// brl_addr - address stage and output register
// Forms x + y * frame_width and holds the finished pixel beat.
// ----------------------------------------------------------------------------
module brl_addr
  import brl_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pix_valid_i,
  output logic                   pix_ready_o,
  input  pixel_t                 pix_i,
  input  logic [FW_W-1:0]        frame_width_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o,
  output logic                   out_last_o
);

  logic                         ov_q, ov_d;
  logic [OUT_TDATA_W-1:0]       data_q, data_d;
  logic                         last_q, last_d;
  logic [COORD_W+FW_W-1:0]      prod;
  logic [ADDR_W-1:0]            addr;
  logic                         take;

  assign pix_ready_o = !ov_q || out_ready_i;
  assign take        = pix_valid_i && pix_ready_o;

  // linear address, wraps at the field width
  assign prod = pix_i.y * frame_width_i;
  assign addr = prod[ADDR_W-1:0] + {{(ADDR_W-COORD_W){1'b0}}, pix_i.x};

  always_comb begin
    ov_d   = ov_q;
    data_d = data_q;
    last_d = last_q;
    if (take) begin
      ov_d   = 1'b1;
      data_d = {addr, pix_i.y, pix_i.x};
      last_d = pix_i.last;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = data_q;
  assign out_last_o  = last_q;

endmodule

@@ sv/bresenham_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer - integer Bresenham line rasteriser
// Walks a line between two endpoints and emits one pixel per step beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser = 0 loads endpoints from tdata, tuser = 1 asks for
//   the next pixel. A load abandons any line in progress and gives no beat;
//   a step with no line active is dropped.
//   Output stream: one beat per pixel carrying x, y and the linear address
//   x + y * frame_width (mod 2^24); tlast marks the final pixel of a line.
//   APB port: frame_width at byte address 0; the user must write it only while idle, the block does not enforce this.
// Timing:
//   An accepted step beat is registered first by the walk stage in its pixel
//   register, then by the address stage in its output register.
//   One beat per cycle in and out while the sink does not stall; the walk
//   state registers update on each accepted beat.
// Reset: no line active, frame_width = 1024, output empty.
// Stall: a held output beat and the pixel register behind it absorb two
//   pixels; tready drops only when both are full and the sink is stalled.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer
  import brl_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: x_start[11:0], y_start[23:12], x_end[35:24], y_end[47:36]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: opcode[0]
  input  logic                   s_axis_tuser,
  // output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: pixel_x[11:0], pixel_y[23:12], pixel_address[47:24]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  logic            pix_valid, pix_ready;
  pixel_t          pix;
  logic [FW_W-1:0] frame_width;

  brl_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .frame_width_o (frame_width)
  );

  brl_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tuser),
    .x_start_i   (s_axis_tdata[COORD_W-1:0]),
    .y_start_i   (s_axis_tdata[2*COORD_W-1:COORD_W]),
    .x_end_i     (s_axis_tdata[3*COORD_W-1:2*COORD_W]),
    .y_end_i     (s_axis_tdata[4*COORD_W-1:3*COORD_W]),
    .pix_valid_o (pix_valid),
    .pix_ready_i (pix_ready),
    .pix_o       (pix)
  );

  brl_addr u_addr (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_valid_i   (pix_valid),
    .pix_ready_o   (pix_ready),
    .pix_i         (pix),
    .frame_width_i (frame_width),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata),
    .out_last_o    (m_axis_tlast)
  );

endmodule

@@ tb/tb_bresenham_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// tb_bresenham_line_rasterizer - self-checking bench for the line rasteriser
// Feeds load and step beats into the input stream, predicts every pixel with
// its own Bresenham walk and checks each output beat against the oldest
// pending pixel. Both streams idle at random but in the last phase; frame_width is
// rewritten over APB between phases, the out-of-range values among them.
// ----------------------------------------------------------------------------
module tb_bresenham_line_rasterizer;
  import brl_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 64;
  localparam logic [APB_AW-1:0] FW_ADDR = {REG_FRAME_WIDTH, 2'b00};

  // one input beat waiting to be sent
  typedef struct {
    logic               op;
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
  } line_beat_t;

  // one predicted pixel
  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [ADDR_W-1:0]  addr;
    logic               last;
  } pixel_rec_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = OP_STEP;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_AW-1:0]      paddr = '0;
  logic [APB_DW-1:0]      pwdata = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  line_beat_t pending_q[$];
  pixel_rec_t due_pixels[$];
  line_beat_t next_beat;
  pixel_rec_t want;

  int  mismatches = 0;
  int  pixels_seen = 0;
  int  cycle_count = 0;
  int  gap_cycles = 0;
  int  stall_cycles = 0;
  int  hold_cycles = 0;
  bit  sink_held = 1'b0;
  bit  idle_en = 1'b1;

  // predictor state
  logic               line_on = 1'b0;
  logic               x_major = 1'b0;
  logic               minor_down = 1'b0;
  logic [COORD_W-1:0] cur_x = '0;
  logic [COORD_W-1:0] cur_y = '0;
  logic [COORD_W-1:0] major_stop = '0;
  logic [COORD_W-1:0] span_minor = '0;
  logic [COORD_W-1:0] span_major = '0;
  int                 err_term = 0;
  logic [FW_W-1:0]    fw_model = FW_RESET;

  bresenham_line_rasterizer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // latch a new line: pick the major axis, order the endpoints upward
  function automatic void start_line(input logic [COORD_W-1:0] xs, ys, xe, ye);
    int dx;
    int dy;
    int adx;
    int ady;
    dx  = int'(xe) - int'(xs);
    dy  = int'(ye) - int'(ys);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    minor_down = !((dx > 0 && dy > 0) || (dx < 0 && dy < 0));
    x_major = adx > ady;
    if (x_major) begin
      if (dx < 0) begin
        cur_x = xe; cur_y = ye; major_stop = xs;
      end else begin
        cur_x = xs; cur_y = ys; major_stop = xe;
      end
      span_major = adx[COORD_W-1:0];
      span_minor = ady[COORD_W-1:0];
    end else begin
      if (dy < 0) begin
        cur_x = xe; cur_y = ye; major_stop = ys;
      end else begin
        cur_x = xs; cur_y = ys; major_stop = ye;
      end
      span_major = ady[COORD_W-1:0];
      span_minor = adx[COORD_W-1:0];
    end
    err_term = 2 * int'(span_minor) - int'(span_major);
    line_on = 1'b1;
  endfunction

  // emit the current pixel and advance the walk by one step
  function automatic void walk_pixel();
    pixel_rec_t px;
    logic [COORD_W-1:0] major_pos;
    logic [47:0] full;
    if (line_on) begin
      major_pos = x_major ? cur_x : cur_y;
      full = 48'(cur_x) + 48'(cur_y) * 48'(fw_model);
      px.x = cur_x;
      px.y = cur_y;
      px.addr = full[ADDR_W-1:0];
      px.last = (major_pos == major_stop);
      due_pixels.push_back(px);
      if (px.last) begin
        line_on = 1'b0;
      end else begin
        if (x_major) cur_x = cur_x + 1'b1;
        else cur_y = cur_y + 1'b1;
        if (err_term < 0) begin
          err_term += 2 * int'(span_minor);
        end else begin
          err_term += 2 * (int'(span_minor) - int'(span_major));
          if (x_major) cur_y = minor_down ? cur_y - 1'b1 : cur_y + 1'b1;
          else cur_x = minor_down ? cur_x - 1'b1 : cur_x + 1'b1;
        end
      end
    end
  endfunction

  task automatic queue_step();
    line_beat_t b;
    b = '{op: OP_STEP, xs: '0, ys: '0, xe: '0, ye: '0};
    pending_q.push_back(b);
  endtask

  // a load followed by a number of step beats
  task automatic queue_line(input logic [COORD_W-1:0] xs, ys, xe, ye, input int nsteps);
    line_beat_t b;
    b = '{op: OP_LOAD, xs: xs, ys: ys, xe: xe, ye: ye};
    pending_q.push_back(b);
    repeat (nsteps) queue_step();
  endtask

  function automatic logic [COORD_W-1:0] coord_near(input logic [COORD_W-1:0] c, input int lim);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * lim)) - lim;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[COORD_W-1:0];
  endfunction

  // mostly complete short lines at random places; some broken or stray beats
  task automatic queue_random_lines(input int budget);
    int kind;
    int lim;
    int sx;
    int sy;
    int nsteps;
    logic [COORD_W-1:0] xs, ys, xe, ye;
    while (budget > 0) begin
      kind = $urandom_range(0, 15);
      xs = COORD_W'($urandom_range(0, 4095));
      ys = COORD_W'($urandom_range(0, 4095));
      if (kind == 0) begin
        queue_step();
        budget--;
      end else begin
        if (kind == 1) begin
          // far endpoints, abandoned after a few pixels
          xe = COORD_W'($urandom_range(0, 4095));
          ye = COORD_W'($urandom_range(0, 4095));
          nsteps = $urandom_range(0, 5);
        end else begin
          lim = ($urandom_range(0, 7) == 0) ? 48 : 6;
          xe = coord_near(xs, lim);
          ye = coord_near(ys, lim);
          sx = int'(xe) - int'(xs);
          sy = int'(ye) - int'(ys);
          if (sx < 0) sx = -sx;
          if (sy < 0) sy = -sy;
          nsteps = ((sx > sy) ? sx : sy) + 1;
          if (kind == 2) nsteps = $urandom_range(0, nsteps - 1);
          else if (kind == 3) nsteps++;
        end
        queue_line(xs, ys, xe, ye, nsteps);
        budget -= nsteps + 1;
      end
    end
  endtask

  // all beats sent, all pixels out, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || due_pixels.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // APB write of frame_width, then read it back
  task automatic write_frame_width(input logic [FW_W-1:0] val);
    logic [APB_DW-1:0] rd;
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= FW_ADDR;
    pwdata <= {{(APB_DW-FW_W){1'b0}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    fw_model = val;
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel <= 1'b0; penable <= 1'b0;
    if (rd !== {{(APB_DW-FW_W){1'b0}}, val}) begin
      $display("%0t: frame_width read back expected %0d got %0d", $time, val, rd);
      mismatches++;
    end
  endtask

  // stimulus
  initial begin
    logic [FW_W-1:0] fw_plan[6];
    fw_plan = '{13'd1024, 13'd1, 13'd4096, 13'd8191, 13'd0, 13'd0};
    fw_plan[5] = FW_W'($urandom_range(1, 4096));
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // step before any line, single points, extremes, both directions
    queue_step();
    queue_line(12'd0, 12'd0, 12'd0, 12'd0, 2);
    queue_line(12'd4095, 12'd4095, 12'd4095, 12'd4095, 1);
    queue_line(12'd4095, 12'd0, 12'd0, 12'd0, 3);
    queue_line(12'd0, 12'd4095, 12'd0, 12'd0, 2);
    queue_line(12'd0, 12'd0, 12'd4095, 12'd4095, 3);
    queue_line(12'd4095, 12'd0, 12'd0, 12'd4095, 2);
    queue_line(12'd10, 12'd20, 12'd13, 12'd19, 4);

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        wait_idle();
        write_frame_width(fw_plan[p]);
      end
      if (p == 5) idle_en = 1'b0;
      // corner pixels: address overflow at wide frames
      queue_line(12'd4095, 12'd4095, 12'd4095, 12'd4095, 1);
      queue_line(12'd0, 12'd0, 12'd0, 12'd0, 1);
      queue_random_lines(95);
    end

    wait_idle();
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // input driver: predicts on every accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_LOAD)
          start_line(s_axis_tdata[11:0], s_axis_tdata[23:12],
                     s_axis_tdata[35:24], s_axis_tdata[47:36]);
        else
          walk_pixel();
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_cycles > 0) begin
          gap_cycles <= gap_cycles - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() != 0 && idle_en && $urandom_range(0, 4) == 0) begin
          gap_cycles <= $urandom_range(0, 2);
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          next_beat = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= next_beat.op;
          s_axis_tdata <= {next_beat.ye, next_beat.xe, next_beat.ys, next_beat.xs};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // one long sink hold-off while beats keep arriving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
      end else if (!sink_held && pixels_seen >= 150 && s_axis_tvalid) begin
        sink_held <= 1'b1;
        hold_cycles <= HOLD_CYCLES;
      end
    end
  end

  // output monitor and sink back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        pixels_seen <= pixels_seen + 1;
        if (due_pixels.size() == 0) begin
          $display("%0t: unexpected pixel x=%0d y=%0d addr=%0d last=%0b", $time,
                   m_axis_tdata[11:0], m_axis_tdata[23:12], m_axis_tdata[47:24],
                   m_axis_tlast);
          mismatches++;
        end else begin
          want = due_pixels.pop_front();
          if (m_axis_tdata[11:0] !== want.x) begin
            $display("%0t: pixel_x expected %0d got %0d", $time, want.x, m_axis_tdata[11:0]);
            mismatches++;
          end
          if (m_axis_tdata[23:12] !== want.y) begin
            $display("%0t: pixel_y expected %0d got %0d", $time, want.y, m_axis_tdata[23:12]);
            mismatches++;
          end
          if (m_axis_tdata[47:24] !== want.addr) begin
            $display("%0t: pixel_address expected %0d got %0d", $time, want.addr,
                     m_axis_tdata[47:24]);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: last_pixel expected %0b got %0b", $time, want.last, m_axis_tlast);
            mismatches++;
          end
        end
      end
      // held off while the long hold runs, then short stalls
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
      end else if (stall_cycles > 0) begin
        stall_cycles <= stall_cycles - 1;
        m_axis_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_cycles <= $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      cycle_count <= cycle_count + 1;
    end
  end

endmodule
